>>> rtl/core/crt_pkg.sv
package crt_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int LSN_W      = 64;

  localparam int IN_DATA_W  = 2 * LSN_W;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = ((LSN_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 1;

  localparam logic       CMD_RECORD = 1'b0;
  localparam logic       CMD_ACK    = 1'b1;
  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_COMMIT = 2'd1;
  localparam logic [1:0] ACT_OTHER  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LSN_W-1:0] restart_hint;
    logic [CNT_W-1:0] pending_count;
    logic             overflow;
  } crt_result_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(RING_DEPTH - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

endpackage

>>> rtl/core/crt_ram.sv
module crt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/crt_ctrl.sv
module crt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic [1:0]                action,
  input  logic [crt_pkg::LSN_W-1:0] lsn,
  input  logic [crt_pkg::LSN_W-1:0] flush_lsn,
  output logic                      wr_en,
  output logic [crt_pkg::IDX_W-1:0] wr_addr,
  output logic [crt_pkg::LSN_W-1:0] wr_data,
  output logic [crt_pkg::IDX_W-1:0] rd_addr,
  input  logic [crt_pkg::LSN_W-1:0] rd_data,
  input  logic                      out_free,
  output logic                      res_valid,
  output crt_pkg::crt_result_t      res
);

  import crt_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [LSN_W-1:0] flush, flush_next;
  logic [LSN_W-1:0] hint, hint_next;
  logic             ovf, ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    flush <= flush_next;
    hint  <= hint_next;
    ovf   <= ovf_next;
  end

  // The head entry is read in the cycle an acknowledgement is taken and again
  // after every pop, so each compare sees the entry that is now oldest.
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    flush_next = flush;
    hint_next  = hint;
    ovf_next   = ovf;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    res_valid  = 1'b0;
    rd_addr    = head;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          flush_next = flush_lsn;
          hint_next  = '0;
          ovf_next   = 1'b0;
          if (command == CMD_RECORD) begin
            if (action == ACT_COMMIT) begin
              if (count == CNT_W'(RING_DEPTH)) begin
                ovf_next = 1'b1;
              end else begin
                wr_en      = 1'b1;
                tail_next  = ring_next(tail);
                count_next = count + CNT_W'(1);
              end
            end
            state_next = ST_DONE;
          end else if (count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_addr = ring_next(head);
        if (rd_data <= flush) begin
          hint_next  = rd_data + LSN_W'(1);
          head_next  = ring_next(head);
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = ST_DONE;
          end
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wr_addr           = tail;
  assign wr_data           = lsn;
  assign res.restart_hint  = hint;
  assign res.pending_count = count;
  assign res.overflow      = ovf;

endmodule

>>> rtl/core/commit_ack_restart_tracker.sv
// Channel  Dir  tdata (low bit up)                      tuser (low bit up)
// s_axis   in   lsn[63:0], flush_lsn[127:64]            command[0], action[2:1]
// m_axis   out  restart_hint[63:0], pending_count[70:64] overflow[0]
//
// A streamed record passes from acceptance through ST_DONE into the output register.
// In ST_WALK an acknowledgement compares entries in turn from the head: every popped
// entry, and the entry that stops the walk if one does; each compare follows a
// registered read of the commit ring memory.
// Reset is synchronous and empties the ring; the ring memory needs no clearing.
// A result waits in the output register while the next word is taken.
module commit_ack_restart_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [crt_pkg::IN_DATA_W-1:0]  s_tdata,  // lsn, flush_lsn
  input  logic [crt_pkg::IN_USER_W-1:0]  s_tuser,  // command, action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [crt_pkg::OUT_DATA_W-1:0] m_tdata,  // restart_hint, pending_count, zero pad
  output logic [crt_pkg::OUT_USER_W-1:0] m_tuser   // overflow
);

  import crt_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [LSN_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [LSN_W-1:0] rd_data;
  logic             out_free;
  logic             res_valid;
  crt_result_t      res;
  crt_result_t      out_res;

  crt_ram #(
    .WIDTH (LSN_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .command   (s_tuser[0]),
    .action    (s_tuser[2:1]),
    .lsn       (s_tdata[LSN_W-1:0]),
    .flush_lsn (s_tdata[2*LSN_W-1:LSN_W]),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {(OUT_DATA_W - LSN_W - CNT_W)'(0), out_res.pending_count,
                    out_res.restart_hint};
  assign m_tuser = out_res.overflow;

endmodule

>>> rtl/core/crt_checker.sv
module crt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [crt_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [crt_pkg::OUT_USER_W-1:0] m_tuser
);

  import crt_pkg::*;

  logic [CNT_W-1:0] pend;
  logic             s_acc;

  assign pend  = m_tdata[LSN_W +: CNT_W];
  assign s_acc = s_tvalid && s_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend <= CNT_W'(RING_DEPTH))
    else $error("pending count above ring depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> pend == CNT_W'(RING_DEPTH) && m_tdata[LSN_W-1:0] == '0)
    else $error("overflow without a full ring or with a restart hint");

  a_no_accept_next: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("two words accepted in consecutive cycles");

endmodule

bind commit_ack_restart_tracker crt_checker u_crt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
